// File: src/mh2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared constants, job type and mixing helpers for the MurmurHash2 core.
// ----------------------------------------------------------------------------
package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd97;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    // What the back end does with one word.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_FULL,
        OP_TAIL
    } t_op;

    // One classified word, handed from front to back.
    typedef struct packed {
        logic [31:0] data;   // mixed k for a full word, masked bytes for a tail
        t_op         op;
        logic        first;  // first word of a key: start from init
        logic        last;   // last word of a key: finish and emit
        logic [31:0] init;   // seed XOR key length
    } t_job;

    // Low 32 bits of x * MIX_MUL.
    function automatic logic [31:0] mul_m(input logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, MIX_MUL};
        return p[31:0];
    endfunction

endpackage
`default_nettype wire

// File: src/mh2_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_front
// Accepts key words, classifies them and runs the two-multiply word mix.
// ----------------------------------------------------------------------------
module mh2_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_seed,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_data_word,
    input  wire logic [2:0]    i_valid_bytes,
    input  wire logic          i_last_word,
    input  wire logic [31:0]   i_key_length,
    output logic               o_push,
    output mh2_pkg::t_job      o_job,
    input  wire logic          i_full
);
    import mh2_pkg::*;

    logic        r_a_valid;
    logic [31:0] r_a_data;
    t_op         r_a_op;
    logic        r_a_first;
    logic        r_a_last;
    logic [31:0] r_a_init;
    logic        r_in_msg;

    logic        accept;
    t_op         n_op;
    logic [31:0] tail_mask;
    logic [31:0] n_data;
    logic [31:0] k_shr;

    assign o_push  = r_a_valid && !i_full;
    assign o_ready = !r_a_valid || o_push;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (!i_last_word || i_valid_bytes >= FULL_BYTES) begin
            n_op = OP_FULL;
        end else if (i_valid_bytes == 3'd0) begin
            n_op = OP_NONE;
        end else begin
            n_op = OP_TAIL;
        end
        case (i_valid_bytes)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            3'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'hffff_ffff;
        endcase
        n_data = (n_op == OP_FULL) ? mul_m(i_data_word) : (i_data_word & tail_mask);
    end

    // Second half of the word mix, straight into the queue.
    assign k_shr = r_a_data ^ (r_a_data >> MIX_SHIFT);

    always_comb begin
        o_job.data  = (r_a_op == OP_FULL) ? mul_m(k_shr) : r_a_data;
        o_job.op    = r_a_op;
        o_job.first = r_a_first;
        o_job.last  = r_a_last;
        o_job.init  = r_a_init;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_in_msg  <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_in_msg  <= !i_last_word;
            end else if (o_push) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_data  <= n_data;
            r_a_op    <= n_op;
            r_a_first <= !r_in_msg;
            r_a_last  <= i_last_word;
            r_a_init  <= i_seed ^ i_key_length;
        end
    end

endmodule
`default_nettype wire

// File: src/mh2_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module mh2_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mh2_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output mh2_pkg::t_job      o_job,
    output logic               o_empty
);
    import mh2_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: src/mh2_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_back
// Folds jobs into the running hash, finishes the key and holds the result.
// ----------------------------------------------------------------------------
module mh2_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mh2_pkg::t_job i_job,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_hash_value
);
    import mh2_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIN1,
        S_FIN2
    } t_state;

    t_state      r_state;
    logic [31:0] r_h;
    logic        r_out_valid;
    logic [31:0] r_hash;

    logic [31:0] h_in;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [31:0] step_h;
    logic        out_free;

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash;
    assign out_free     = !r_out_valid || i_ready;

    always_comb begin
        h_in = i_job.first ? i_job.init : r_h;
        if (r_state == S_FIN1) begin
            mul_a = r_h ^ (r_h >> FIN_SHIFT_A);
        end else if (i_job.op == OP_FULL) begin
            mul_a = h_in;
        end else begin
            mul_a = h_in ^ i_job.data;
        end
        prod = mul_m(mul_a);
        case (i_job.op)
            OP_FULL: step_h = prod ^ i_job.data;
            OP_TAIL: step_h = prod;
            default: step_h = h_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_h         <= '0;
        end else begin
            // drop a taken result; the finish state reloads the register itself
            if (r_out_valid && i_ready && r_state != S_FIN2) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_h <= step_h;
                        if (i_job.last) begin
                            r_state <= S_FIN1;
                        end
                    end
                end
                S_FIN1: begin
                    r_h     <= prod;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    if (out_free) begin
                        r_hash      <= r_h ^ (r_h >> FIN_SHIFT_B);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/murmur2_hash32_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_hash32_core
// Streaming 32-bit MurmurHash2 engine.
//
// Usage: send a key as little-endian 32-bit words on the input channel
// (i_valid/o_ready), first key byte in bits 7:0. Mark the final word with
// i_last_word and give its byte count (0..4) in i_valid_bytes; earlier words
// are always full. i_key_length is sampled on the first word of each key and
// XORed with the seed to start the hash. One hash per key comes out on the
// output channel (o_valid/i_ready).
// Throughput: one word per cycle for words that are not last, unless the
// queue is full; a last word holds the back end through fold, multiply and
// final shift, set by the single shared 32-bit multiplier in its hash loop.
// After the last word is accepted, the key passes the mix stage, the queue,
// the fold, the finish multiply and the final shift before o_valid rises.
// The seed register (i_cfg_valid/o_cfg_ready) is always ready; write it only
// while the core is idle. Reset sets the seed to 97 and empties every stage.
// On a receiver stall the result waits in the output register; the back end
// folds on up to the next key's finish, and the front end and queue fill up.
// ----------------------------------------------------------------------------
module murmur2_hash32_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // seed register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_hash_seed,
    // key words in
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last_word,
    input  wire logic [31:0] i_key_length,
    // hash out
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value
);
    import mh2_pkg::*;

    logic [31:0] r_seed;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_job        front_job;
    t_job        back_job;

    // Seed register: always accept a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_hash_seed;
        end
    end

    // Front: classify each word and run the k mix.
    mh2_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed        (r_seed),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .i_key_length  (i_key_length),
        .o_push        (push),
        .o_job         (front_job),
        .i_full        (full)
    );

    // Queue: decouple the mix pipeline from the hash loop.
    mh2_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (back_job),
        .o_empty (empty)
    );

    // Back: fold into the running hash, finish, hold the result.
    mh2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (back_job),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
`default_nettype wire
